@@ rtl/gemm_a_panel_pack_address_gen_unit_defines.svh @@
// assertion macros for the a-panel pack address generator
`ifndef GEMM_A_PANEL_PACK_ADDRESS_GEN_UNIT_DEFINES_SVH
`define GEMM_A_PANEL_PACK_ADDRESS_GEN_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define GAPG_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define GAPG_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/gapg_pkg.sv @@
// constants, config type and helpers for the a-panel pack address generator
package gapg_pkg;

	localparam int unsigned PANEL_ROWS = 6;
	localparam int unsigned MAX_DIM    = 4096;

	localparam int unsigned COUNT_W   = 13;
	localparam int unsigned LANE_W    = 3;
	localparam int unsigned DEPTH_W   = 12;
	localparam int unsigned ROW_W     = 13;
	localparam int unsigned LD_W      = 16;
	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned SRC_PROD_W = ROW_W + LD_W;
	localparam int unsigned DST_PROD_W = ROW_W + COUNT_W;
	localparam int unsigned DST_ADD_W  = 15;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEPTH_COUNT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEADING_DIM   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LAYOUT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_BASE     = 3'd5;

	typedef struct packed {
		logic [COUNT_W-1:0] row_count;
		logic [COUNT_W-1:0] depth_count;
		logic [LD_W-1:0]    leading_dim;
		logic               column_layout;
		logic [ADDR_W-1:0]  source_base;
		logic [ADDR_W-1:0]  dest_base;
	} cfg_t;

	// zero acts as one, above max acts as max
	function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
		logic [COUNT_W-1:0] r;
		if (v == '0) begin
			r = COUNT_W'(1);
		end else if (v > COUNT_W'(MAX_DIM)) begin
			r = COUNT_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

@@ rtl/gapg_ifs.sv @@
// handshake interfaces for slot requests, slot results and config writes
interface gapg_req_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface gapg_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] src_addr;
	logic [31:0] dst_addr;
	logic        zero_fill;
	logic        last_slot;

	modport source (output valid, output src_addr, output dst_addr, output zero_fill,
		output last_slot, input ready);
	modport sink (input valid, input src_addr, input dst_addr, input zero_fill,
		input last_slot, output ready);
endinterface

interface gapg_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/gemm_a_panel_pack_address_gen_unit.sv @@
// a-panel pack address generator: one packed-buffer slot address pair per request beat
// Each accepted request beat (restart=1 starts over at the first slot) yields one result
// beat with the source and packed-destination element addresses of the next slot, walked
// panel by panel (six rows each), column by column, lane by lane. Lanes past the row count
// come out zero-fill with a source address of zero; the final slot of the block carries
// last_slot and the sequence then wraps. One slot per cycle is sustained while the result
// side is ready; each result is registered in turn by counter capture, address multipliers
// and final adds, the middle stage holding the row/column-times-stride and panel-times-depth products.
// Config writes are always ready and must only be made while no slot is in flight.
module gemm_a_panel_pack_address_gen_unit
	import gapg_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	gapg_req_if.sink   req,
	gapg_rsp_if.source rsp,
	gapg_cfg_if.sink   cfg
);

	cfg_t cfg_q;

	logic [LANE_W-1:0]  lane_q;
	logic [DEPTH_W-1:0] depth_q;
	logic [ROW_W-1:0]   prb_q;

	logic [COUNT_W-1:0] mc;
	logic [COUNT_W-1:0] kc;
	logic [LANE_W-1:0]  cur_lane;
	logic [DEPTH_W-1:0] cur_depth;
	logic [ROW_W-1:0]   cur_prb;
	logic [ROW_W-1:0]   cur_row;
	logic               lane_end;
	logic               depth_end;
	logic               panel_end;
	logic               acc;
	logic               en1;
	logic               en2;
	logic               en3;

	logic               v_s1;
	logic [ROW_W-1:0]   row_s1;
	logic [DEPTH_W-1:0] depth_s1;
	logic [LANE_W-1:0]  lane_s1;
	logic [ROW_W-1:0]   prb_s1;
	logic               fill_s1;
	logic               last_s1;

	logic [ROW_W-1:0]      src_mul_a;
	logic [SRC_PROD_W-1:0] src_prod;
	logic [DST_PROD_W-1:0] dst_prod;
	logic [DST_ADD_W-1:0]  dst_add;

	logic                  v_s2;
	logic [SRC_PROD_W-1:0] src_prod_s2;
	logic [ROW_W-1:0]      src_add_s2;
	logic [DST_PROD_W-1:0] dst_prod_s2;
	logic [DST_ADD_W-1:0]  dst_add_s2;
	logic                  fill_s2;
	logic                  last_s2;

	logic              v_s3;
	logic [ADDR_W-1:0] src_s3;
	logic [ADDR_W-1:0] dst_s3;
	logic              fill_s3;
	logic              last_s3;

	// config registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_count     <= COUNT_W'(PANEL_ROWS);
			cfg_q.depth_count   <= COUNT_W'(8);
			cfg_q.leading_dim   <= LD_W'(1);
			cfg_q.column_layout <= 1'b0;
			cfg_q.source_base   <= '0;
			cfg_q.dest_base     <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ROW_COUNT:     cfg_q.row_count     <= cfg.data[COUNT_W-1:0];
				REG_DEPTH_COUNT:   cfg_q.depth_count   <= cfg.data[COUNT_W-1:0];
				REG_LEADING_DIM:   cfg_q.leading_dim   <= cfg.data[LD_W-1:0];
				REG_COLUMN_LAYOUT: cfg_q.column_layout <= cfg.data[0];
				REG_SOURCE_BASE:   cfg_q.source_base   <= cfg.data;
				REG_DEST_BASE:     cfg_q.dest_base     <= cfg.data;
				default: ;
			endcase
		end
	end

	// flow control
	assign en3 = !v_s3 || rsp.ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign req.ready = en1;
	assign acc = req.valid && en1;

	// slot counters
	assign mc = clamp_count(cfg_q.row_count);
	assign kc = clamp_count(cfg_q.depth_count);

	assign cur_lane  = req.restart ? '0 : lane_q;
	assign cur_depth = req.restart ? '0 : depth_q;
	assign cur_prb   = req.restart ? '0 : prb_q;
	assign cur_row   = cur_prb + ROW_W'(cur_lane);

	assign lane_end  = ({1'b0, cur_lane} + 4'd1) >= 4'(PANEL_ROWS);
	assign depth_end = ({1'b0, cur_depth} + 13'd1) >= kc;
	assign panel_end = ({1'b0, cur_prb} + 14'(PANEL_ROWS)) >= {1'b0, mc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_q  <= '0;
			depth_q <= '0;
			prb_q   <= '0;
		end else if (acc) begin
			if (!lane_end) begin
				lane_q  <= cur_lane + LANE_W'(1);
				depth_q <= cur_depth;
				prb_q   <= cur_prb;
			end else begin
				lane_q <= '0;
				if (!depth_end) begin
					depth_q <= cur_depth + DEPTH_W'(1);
					prb_q   <= cur_prb;
				end else begin
					depth_q <= '0;
					prb_q   <= panel_end ? '0 : cur_prb + ROW_W'(PANEL_ROWS);
				end
			end
		end
	end

	// stage 1: captured slot coordinates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			row_s1   <= cur_row;
			depth_s1 <= cur_depth;
			lane_s1  <= cur_lane;
			prb_s1   <= cur_prb;
			fill_s1  <= cur_row >= mc;
			last_s1  <= lane_end && depth_end && panel_end;
		end
	end

	// stage 2: products
	assign src_mul_a = cfg_q.column_layout ? {1'b0, depth_s1} : row_s1;
	assign src_prod  = src_mul_a * cfg_q.leading_dim;
	assign dst_prod  = prb_s1 * kc;
	assign dst_add   = DST_ADD_W'(depth_s1) * DST_ADD_W'(PANEL_ROWS) + DST_ADD_W'(lane_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			src_prod_s2 <= src_prod;
			src_add_s2  <= cfg_q.column_layout ? row_s1 : {1'b0, depth_s1};
			dst_prod_s2 <= dst_prod;
			dst_add_s2  <= dst_add;
			fill_s2     <= fill_s1;
			last_s2     <= last_s1;
		end
	end

	// stage 3: final address sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			src_s3  <= fill_s2 ? '0 : cfg_q.source_base + ADDR_W'(src_prod_s2)
				+ ADDR_W'(src_add_s2);
			dst_s3  <= cfg_q.dest_base + ADDR_W'(dst_prod_s2) + ADDR_W'(dst_add_s2);
			fill_s3 <= fill_s2;
			last_s3 <= last_s2;
		end
	end

	assign rsp.valid     = v_s3;
	assign rsp.src_addr  = src_s3;
	assign rsp.dst_addr  = dst_s3;
	assign rsp.zero_fill = fill_s3;
	assign rsp.last_slot = last_s3;

endmodule

@@ rtl/gapg_checker.sv @@
// port-level checks for the a-panel pack address generator, bound to the top level
`include "gemm_a_panel_pack_address_gen_unit_defines.svh"

module gapg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [31:0] rsp_src_addr,
	input logic [31:0] rsp_dst_addr,
	input logic        rsp_zero_fill,
	input logic        rsp_last_slot,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	// zero-fill beats never carry a source address
	`GAPG_ASSERT_NOW(a_fill_src_zero, rsp_valid && rsp_zero_fill, rsp_src_addr == 32'd0, "zero-fill beat with nonzero source address")

	// an empty output register always leaves the request side open
	`GAPG_ASSERT_NOW(a_ready_when_empty, !rsp_valid, req_ready, "request stalled with empty output")

	// config writes are never back-pressured
	`GAPG_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "config write stalled")

	// stalled result beat holds
	`GAPG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_src_addr) && $stable(rsp_dst_addr) && $stable(rsp_zero_fill) && $stable(rsp_last_slot), "stalled result beat changed")

endmodule

bind gemm_a_panel_pack_address_gen_unit gapg_checker u_gapg_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_src_addr (rsp.src_addr),
	.rsp_dst_addr (rsp.dst_addr),
	.rsp_zero_fill(rsp.zero_fill),
	.rsp_last_slot(rsp.last_slot),
	.cfg_valid    (cfg.valid),
	.cfg_ready    (cfg.ready)
);
